// ===== sv/gnc_pkg.sv =====
// gnc_pkg: shared constants, types and the elaboration-time sine table for the
// gradient noise corner core. No dependencies.
`default_nettype none

package gnc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_BITS = 12;

    localparam int CELL_W  = 16;
    localparam int POINT_W = 32;
    localparam int OUT_W   = 20;

    localparam int S_TDATA_W = 96;   // 2*CELL_W + 2*POINT_W
    localparam int M_TDATA_W = 24;   // OUT_W padded to bytes

    localparam logic [31:0] HASH_M1 = 32'd3284157443;
    localparam logic [31:0] HASH_M2 = 32'd1911520717;
    localparam logic [31:0] HASH_M3 = 32'd2048419325;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // quarter turn in angle steps, and the address width for 0..QUARTER
    localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
    localparam int ROM_AW  = ANGLE_BITS - 1;

    localparam int OFF_W  = FRAC_BITS + 2;         // offsets in [-2,2)
    localparam int GRAD_W = FRAC_BITS + 2;         // gradient in [-1,1]
    localparam int PROD_W = OFF_W + GRAD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int DIFF_W = ((CELL_W + FRAC_BITS > POINT_W) ? CELL_W + FRAC_BITS : POINT_W) + 1;

    localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (OUT_W - 1));

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    // load enables, one per register stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    typedef logic [0:QUARTER][FRAC_BITS:0] sine_rom_t;

    // (2n)(2n+1) for the Taylor terms of sine
    localparam logic [63:0] TAYLOR_DIV [9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    // sin(pi/2 * r / QUARTER) in Q1.FRAC_BITS, evaluated only at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        rom = '0;
        for (int r = 0; r <= QUARTER; r++) begin
            x = (PI_HALF_Q30 * 64'(r) + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            for (int n = 1; n <= 9; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > 64'sd1073741824) begin
                sum = 64'sd1073741824;
            end
            rom[r] = (FRAC_BITS + 1)'(($unsigned(sum) + (64'd1 << (29 - FRAC_BITS)))
                                      >> (30 - FRAC_BITS));
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== sv/gnc_front.sv =====
// gnc_front: stages 1 to 3, corner hash (three wrapping multiplies) and the
// saturated point-minus-corner offsets. Depends on gnc_pkg.
`default_nettype none

module gnc_front (
    input  wire logic                                  aclk,
    input  wire gnc_pkg::stage_en_t                    en,
    input  wire logic signed [gnc_pkg::CELL_W-1:0]     cell_x,
    input  wire logic signed [gnc_pkg::CELL_W-1:0]     cell_y,
    input  wire logic signed [gnc_pkg::POINT_W-1:0]    point_x,
    input  wire logic signed [gnc_pkg::POINT_W-1:0]    point_y,
    output logic [gnc_pkg::ANGLE_BITS-1:0]             angle_idx,
    output logic signed [gnc_pkg::OFF_W-1:0]           dx,
    output logic signed [gnc_pkg::OFF_W-1:0]           dy
);

    localparam int DW = gnc_pkg::DIFF_W;
    localparam int OW = gnc_pkg::OFF_W;
    localparam int AB = gnc_pkg::ANGLE_BITS;

    localparam logic signed [DW-1:0] OFF_HI =
        (DW'(1) <<< (gnc_pkg::FRAC_BITS + 1)) - DW'(1);
    localparam logic signed [DW-1:0] OFF_LO = -(DW'(1) <<< (gnc_pkg::FRAC_BITS + 1));

    function automatic logic signed [OW-1:0] sat_off(input logic signed [DW-1:0] d);
        logic signed [DW-1:0] s;
        s = d;
        if (d < OFF_LO) begin
            s = OFF_LO;
        end else if (d > OFF_HI) begin
            s = OFF_HI;
        end
        return OW'(s);
    endfunction

    function automatic logic [31:0] rotl16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    // stage 1
    logic [31:0]                  hash1_reg, hash1_next;
    logic [31:0]                  cx_ext;
    logic signed [gnc_pkg::CELL_W-1:0] cy1_reg;
    logic signed [DW-1:0]         diff_x, diff_y;
    logic signed [OW-1:0]         dx1_reg, dy1_reg;
    // stage 2
    logic [31:0]                  hash_a2_reg, hash_b2_reg, hash_b2_next, cy_ext;
    logic signed [OW-1:0]         dx2_reg, dy2_reg;
    // stage 3
    logic [31:0]                  hash3_next;
    logic [AB-1:0]                angle3_reg;
    logic signed [OW-1:0]         dx3_reg, dy3_reg;

    always_comb begin
        cx_ext = 32'(cell_x);
        hash1_next = cx_ext * gnc_pkg::HASH_M1;
        diff_x = DW'(point_x) - (DW'(cell_x) <<< gnc_pkg::FRAC_BITS);
        diff_y = DW'(point_y) - (DW'(cell_y) <<< gnc_pkg::FRAC_BITS);
        cy_ext = 32'(cy1_reg);
        hash_b2_next = (cy_ext ^ rotl16(hash1_reg)) * gnc_pkg::HASH_M2;
        hash3_next = (hash_a2_reg ^ rotl16(hash_b2_reg)) * gnc_pkg::HASH_M3;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            hash1_reg <= hash1_next;
            cy1_reg   <= cell_y;
            dx1_reg   <= sat_off(diff_x);
            dy1_reg   <= sat_off(diff_y);
        end
        if (en.s2) begin
            hash_a2_reg <= hash1_reg;
            hash_b2_reg <= hash_b2_next;
            dx2_reg     <= dx1_reg;
            dy2_reg     <= dy1_reg;
        end
        if (en.s3) begin
            angle3_reg <= hash3_next[31 -: AB];
            dx3_reg    <= dx2_reg;
            dy3_reg    <= dy2_reg;
        end
    end

    assign angle_idx = angle3_reg;
    assign dx = dx3_reg;
    assign dy = dy3_reg;

endmodule

`default_nettype wire

// ===== sv/gnc_sine_rom.sv =====
// gnc_sine_rom: stage 4, dual-port read of the quarter-wave sine table at r
// and QUARTER - r. Depends on gnc_pkg (table contents and widths).
`default_nettype none

module gnc_sine_rom (
    input  wire logic                                  aclk,
    input  wire gnc_pkg::stage_en_t                    en,
    input  wire logic [gnc_pkg::ANGLE_BITS-1:0]        angle_idx,
    input  wire logic signed [gnc_pkg::OFF_W-1:0]      dx_in,
    input  wire logic signed [gnc_pkg::OFF_W-1:0]      dy_in,
    output logic [gnc_pkg::FRAC_BITS:0]                sin_r,
    output logic [gnc_pkg::FRAC_BITS:0]                sin_q,
    output gnc_pkg::quad_t                             quad,
    output logic signed [gnc_pkg::OFF_W-1:0]           dx_out,
    output logic signed [gnc_pkg::OFF_W-1:0]           dy_out
);

    localparam int AW = gnc_pkg::ROM_AW;
    localparam int AB = gnc_pkg::ANGLE_BITS;

    logic [AW-1:0]                    addr_r, addr_q;
    logic [gnc_pkg::FRAC_BITS:0]      sin_r_reg, sin_q_reg;
    gnc_pkg::quad_t                   quad_reg;
    logic signed [gnc_pkg::OFF_W-1:0] dx_reg, dy_reg;

    always_comb begin
        addr_r = {1'b0, angle_idx[AB-3:0]};
        addr_q = AW'(gnc_pkg::QUARTER) - addr_r;
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            sin_r_reg <= gnc_pkg::SINE_ROM[addr_r];
            sin_q_reg <= gnc_pkg::SINE_ROM[addr_q];
            quad_reg  <= gnc_pkg::quad_t'(angle_idx[AB-1 -: 2]);
            dx_reg    <= dx_in;
            dy_reg    <= dy_in;
        end
    end

    assign sin_r  = sin_r_reg;
    assign sin_q  = sin_q_reg;
    assign quad   = quad_reg;
    assign dx_out = dx_reg;
    assign dy_out = dy_reg;

endmodule

`default_nettype wire

// ===== sv/gnc_dot.sv =====
// gnc_dot: stages 5 and 6, gradient sign selection, two products, then sum,
// round half up and saturate to the output range. Depends on gnc_pkg.
`default_nettype none

module gnc_dot (
    input  wire logic                                  aclk,
    input  wire gnc_pkg::stage_en_t                    en,
    input  wire logic [gnc_pkg::FRAC_BITS:0]           sin_r,
    input  wire logic [gnc_pkg::FRAC_BITS:0]           sin_q,
    input  wire gnc_pkg::quad_t                        quad,
    input  wire logic signed [gnc_pkg::OFF_W-1:0]      dx,
    input  wire logic signed [gnc_pkg::OFF_W-1:0]      dy,
    output logic signed [gnc_pkg::OUT_W-1:0]           corner_value
);

    localparam int GW = gnc_pkg::GRAD_W;
    localparam int PW = gnc_pkg::PROD_W;
    localparam int SW = gnc_pkg::SUM_W;

    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (gnc_pkg::FRAC_BITS - 1);
    localparam logic signed [SW-1:0] RES_HI = SW'(gnc_pkg::OUT_MAX);
    localparam logic signed [SW-1:0] RES_LO = SW'(gnc_pkg::OUT_MIN);

    logic signed [GW-1:0] fr, fq, gx, gy;
    logic signed [PW-1:0] prod_x_reg, prod_y_reg, prod_x_next, prod_y_next;
    logic signed [SW-1:0] sum, shifted, clipped;
    logic signed [gnc_pkg::OUT_W-1:0] result_reg;

    always_comb begin
        fr = $signed({1'b0, sin_r});
        fq = $signed({1'b0, sin_q});
        case (quad)
            gnc_pkg::QUAD_I: begin
                gx = fq;
                gy = fr;
            end
            gnc_pkg::QUAD_II: begin
                gx = -fr;
                gy = fq;
            end
            gnc_pkg::QUAD_III: begin
                gx = -fq;
                gy = -fr;
            end
            default: begin
                gx = fr;
                gy = -fq;
            end
        endcase
        prod_x_next = PW'(dx) * PW'(gx);
        prod_y_next = PW'(dy) * PW'(gy);

        // floor((acc + half) / 2^FRAC_BITS)
        sum = SW'(prod_x_reg) + SW'(prod_y_reg) + ROUND_HALF;
        shifted = sum >>> gnc_pkg::FRAC_BITS;
        clipped = shifted;
        if (shifted > RES_HI) begin
            clipped = RES_HI;
        end else if (shifted < RES_LO) begin
            clipped = RES_LO;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (en.s6) begin
            result_reg <= gnc_pkg::OUT_W'(clipped);
        end
    end

    assign corner_value = result_reg;

endmodule

`default_nettype wire

// ===== sv/gradient_noise_corner_2d_core.sv =====
// gradient_noise_corner_2d_core: top level, stream ports, per-stage valid bits
// and stall control. Depends on gnc_pkg, gnc_front, gnc_sine_rom, gnc_dot.
//
//   channel   dir  fields (tdata, low bit first)
//   s_axis    in   cell_x[15:0] cell_y[31:16] point_x[63:32] point_y[95:64]
//   m_axis    out  corner_value[19:0], bits 23:20 zero
//
// One request per cycle sustained while m_tready stays high; an accepted request
// passes through every stage register before m_tvalid rises.
// Stages: hash multiply 1 + offsets, multiply 2, multiply 3, sine table read,
// gradient products, sum/round/saturate into the output register.
// Each stage loads when it is empty or the one after it moves, so a stalled
// m_tready lets empty stages fill before s_tready drops.
// aresetn (sync, active low) clears the valid bits only.
`default_nettype none

module gradient_noise_corner_2d_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // cell_x[15:0], cell_y[31:16], point_x[63:32], point_y[95:64]
    input  wire logic [gnc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // corner_value[19:0], zero pad [23:20]
    output logic [gnc_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int CW = gnc_pkg::CELL_W;
    localparam int PTW = gnc_pkg::POINT_W;

    gnc_pkg::stage_en_t en;
    logic [5:0] valid_reg, valid_next;   // bit 0 is stage 1

    logic signed [CW-1:0]  cell_x, cell_y;
    logic signed [PTW-1:0] point_x, point_y;

    logic [gnc_pkg::ANGLE_BITS-1:0]   angle_idx;
    logic signed [gnc_pkg::OFF_W-1:0] dx3, dy3, dx4, dy4;
    logic [gnc_pkg::FRAC_BITS:0]      sin_r, sin_q;
    gnc_pkg::quad_t                   quad;
    logic signed [gnc_pkg::OUT_W-1:0] corner_value;

    always_comb begin
        en.s6 = !valid_reg[5] || m_tready;
        en.s5 = !valid_reg[4] || en.s6;
        en.s4 = !valid_reg[3] || en.s5;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;

        valid_next[0] = en.s1 ? s_tvalid     : valid_reg[0];
        valid_next[1] = en.s2 ? valid_reg[0] : valid_reg[1];
        valid_next[2] = en.s3 ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en.s4 ? valid_reg[2] : valid_reg[3];
        valid_next[4] = en.s5 ? valid_reg[3] : valid_reg[4];
        valid_next[5] = en.s6 ? valid_reg[4] : valid_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign cell_x  = $signed(s_tdata[CW-1:0]);
    assign cell_y  = $signed(s_tdata[2*CW-1:CW]);
    assign point_x = $signed(s_tdata[2*CW+PTW-1:2*CW]);
    assign point_y = $signed(s_tdata[2*CW+2*PTW-1:2*CW+PTW]);

    gnc_front u_front (
        .aclk      (aclk),
        .en        (en),
        .cell_x    (cell_x),
        .cell_y    (cell_y),
        .point_x   (point_x),
        .point_y   (point_y),
        .angle_idx (angle_idx),
        .dx        (dx3),
        .dy        (dy3)
    );

    gnc_sine_rom u_rom (
        .aclk      (aclk),
        .en        (en),
        .angle_idx (angle_idx),
        .dx_in     (dx3),
        .dy_in     (dy3),
        .sin_r     (sin_r),
        .sin_q     (sin_q),
        .quad      (quad),
        .dx_out    (dx4),
        .dy_out    (dy4)
    );

    gnc_dot u_dot (
        .aclk         (aclk),
        .en           (en),
        .sin_r        (sin_r),
        .sin_q        (sin_q),
        .quad         (quad),
        .dx           (dx4),
        .dy           (dy4),
        .corner_value (corner_value)
    );

    assign s_tready = en.s1;
    assign m_tvalid = valid_reg[5];
    assign m_tdata  = {{(gnc_pkg::M_TDATA_W - gnc_pkg::OUT_W){1'b0}}, corner_value};

endmodule

`default_nettype wire

// ===== sv/gnc_checker.sv =====
// gnc_checker: port-level assertions for gradient_noise_corner_2d_core, and
// the bind that attaches them. Depends on gnc_pkg for port widths.
`default_nettype none

module gnc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [gnc_pkg::S_TDATA_W-1:0]   s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [gnc_pkg::M_TDATA_W-1:0]   m_tdata
);

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty output stage means the whole pipe can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // fixed latency when the output side never stalls
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready |=> m_tvalid)
        else $error("request did not reach output in six cycles");

    // padding above the result stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[gnc_pkg::M_TDATA_W-1:gnc_pkg::OUT_W] == '0))
        else $error("nonzero pad bits on result");

endmodule

bind gradient_noise_corner_2d_core gnc_checker u_gnc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
